>>> hw/rtl/tfr_pkg.sv
// ----------------------------------------------------------------------------
// tfr_pkg
// Shared constants and types of the triangle fill rasterizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tfr_pkg;

   localparam int SCR_W     = 320;
   localparam int SCR_H     = 200;
   localparam int DRAW_ROWS = 199;
   localparam int FRAC_BITS = 16;
   localparam int PIXELS    = SCR_W * SCR_H;
   localparam int ADDR_W    = $clog2(PIXELS);
   localparam int COORD_W   = 12;
   localparam int COLOR_W   = 8;
   localparam int POS_W     = 34;
   localparam int NUM_W     = 32;
   localparam int DEN_W     = 13;
   localparam int DIV_STEPS = NUM_W - 1;

   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;
   localparam logic [1:0] CMD_FILL  = 2'd3;

   typedef struct packed {
      logic                    start;
      logic signed [NUM_W-1:0] num;
      logic signed [DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                    done;
      logic signed [NUM_W-1:0] quot;
   } div_rsp_type;

endpackage

`default_nettype wire

>>> hw/rtl/triangle_fill_rasterizer.sv
// ----------------------------------------------------------------------------
// triangle_fill_rasterizer
// Scanline triangle fill into a 320x200 8-bit frame store.
// ----------------------------------------------------------------------------
// One request on req_* gives exactly one response on rsp_*. req_tuser carries
// the command (clear, write pixel, read pixel, fill triangle), req_tdata the
// vertices and color. rsp_tdata returns the read pixel and the culled flag.
// Work per request:
//   clear       whole store swept, one pixel written per cycle
//   write pixel one RAM write, read pixel one registered RAM read
//   fill        setup by three divides for the split point and slopes of
//               the upper half and two more for the lower half, then a walk
//               over the rows that writes each span pixel by pixel; the
//               single RAM write port sets the span rate.
// After reset the store is swept to zero, with req_tready low.
// A finished response sits in an output register; the next request is taken
// while it waits. If rsp_tready stays low, the following response is held
// inside and no further request is taken until the first one drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module triangle_fill_rasterizer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // x_a[11:0] y_a[23:12] x_b[35:24] y_b[47:36] x_c[59:48] y_c[71:60] color[79:72]
   input  wire logic [79:0] req_tdata,
   // command[1:0]
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // read_value[7:0] culled[8] zero[15:9]
   output logic [15:0]      rsp_tdata
);

   localparam int CW = tfr_pkg::COORD_W;
   localparam int AW = tfr_pkg::ADDR_W;
   localparam int PW = tfr_pkg::POS_W;
   localparam int FB = tfr_pkg::FRAC_BITS;

   localparam logic [4:0] ST_IDLE    = 5'd0;
   localparam logic [4:0] ST_CLEAR   = 5'd1;
   localparam logic [4:0] ST_WRITE   = 5'd2;
   localparam logic [4:0] ST_READ    = 5'd3;
   localparam logic [4:0] ST_RDWAIT  = 5'd4;
   localparam logic [4:0] ST_CULL    = 5'd5;
   localparam logic [4:0] ST_MUL     = 5'd6;
   localparam logic [4:0] ST_X4_GO   = 5'd7;
   localparam logic [4:0] ST_X4_WAIT = 5'd8;
   localparam logic [4:0] ST_LI_GO   = 5'd9;
   localparam logic [4:0] ST_LI_WAIT = 5'd10;
   localparam logic [4:0] ST_RI_GO   = 5'd11;
   localparam logic [4:0] ST_RI_WAIT = 5'd12;
   localparam logic [4:0] ST_ROW     = 5'd13;
   localparam logic [4:0] ST_PIX     = 5'd14;
   localparam logic [4:0] ST_LOW     = 5'd15;
   localparam logic [4:0] ST_FINISH  = 5'd16;

   logic [4:0] state_ff, state_in;
   logic       boot_ff, boot_in;
   logic       phase_ff, phase_in;
   logic [1:0] cmd_ff, cmd_in;
   logic [7:0] color_ff, color_in;
   logic signed [CW-1:0] x1_ff, x1_in, y1_ff, y1_in;
   logic signed [CW-1:0] x2_ff, x2_in, y2_ff, y2_in;
   logic signed [CW-1:0] x3_ff, x3_in, y3_ff, y3_in;
   logic signed [13:0] x4_ff, x4_in;
   logic signed [25:0] prod_ff, prod_in;
   logic signed [tfr_pkg::NUM_W-1:0] li_ff, li_in, ri_ff, ri_in;
   logic signed [PW-1:0] lv_ff, lv_in, rv_ff, rv_in;
   logic signed [12:0] row_ff, row_in;
   logic [12:0] cnt_ff, cnt_in;
   logic signed [16:0] span_addr_ff, span_addr_in;
   logic [9:0] span_cnt_ff, span_cnt_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic [7:0] rd_val_ff, rd_val_in;
   logic culled_ff, culled_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [8:0] rsp_data_ff, rsp_data_in;

   tfr_pkg::div_req_type div_req;
   tfr_pkg::div_rsp_type div_rsp;

   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [7:0]    ram_wdata;
   logic [7:0]    ram_rdata;
   logic [AW-1:0] pix_addr;
   logic          pix_in_range;

   logic signed [CW-1:0] sx1, sy1, sx2, sy2, sx3, sy3, tx, ty;
   logic n1, n2, n3, p1, p2, p3;
   logic signed [14:0] dx_a, dx_b;
   logic signed [12:0] dy_a, dy_b;
   logic signed [17:0] lfl, rfl;
   logic [8:0] lc, rc, r_hi;
   logic signed [10:0] s_col;
   logic [9:0] e_col;
   logic [16:0] row_base;

   tfr_ram #(.DATA_W(tfr_pkg::COLOR_W), .DEPTH(tfr_pkg::PIXELS)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (pix_addr),
      .rd_data (ram_rdata)
   );

   tfr_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_data_ff};

   assign pix_in_range = !x1_ff[CW-1] && (x1_ff < CW'(tfr_pkg::SCR_W))
                      && !y1_ff[CW-1] && (y1_ff < CW'(tfr_pkg::SCR_H));
   assign pix_addr = AW'(AW'(y1_ff[7:0]) * AW'(tfr_pkg::SCR_W) + AW'(x1_ff[8:0]));

   always_comb begin
      // vertex sort by y
      sx1 = x1_ff; sy1 = y1_ff; sx2 = x2_ff; sy2 = y2_ff; sx3 = x3_ff; sy3 = y3_ff;
      if (sy1 > sy2) begin
         tx = sx1; ty = sy1; sx1 = sx2; sy1 = sy2; sx2 = tx; sy2 = ty;
      end
      if (sy1 > sy3) begin
         tx = sx1; ty = sy1; sx1 = sx3; sy1 = sy3; sx3 = tx; sy3 = ty;
      end
      if (sy2 > sy3) begin
         tx = sx2; ty = sy2; sx2 = sx3; sy2 = sy3; sx3 = tx; sy3 = ty;
      end
      tx = '0;
      ty = '0;
   end

   always_comb begin
      n1 = x1_ff[CW-1] || y1_ff[CW-1];
      n2 = x2_ff[CW-1] || y2_ff[CW-1];
      n3 = x3_ff[CW-1] || y3_ff[CW-1];
      p1 = !n1 && (x1_ff >= CW'(tfr_pkg::SCR_W) || y1_ff >= CW'(tfr_pkg::DRAW_ROWS));
      p2 = !n2 && (x2_ff >= CW'(tfr_pkg::SCR_W) || y2_ff >= CW'(tfr_pkg::DRAW_ROWS));
      p3 = !n3 && (x3_ff >= CW'(tfr_pkg::SCR_W) || y3_ff >= CW'(tfr_pkg::DRAW_ROWS));
   end

   // divider operands
   always_comb begin
      if (!phase_ff) begin
         dx_a = 15'(x3_ff) - 15'(x1_ff);
         dy_a = 13'(y3_ff) - 13'(y1_ff);
         dx_b = 15'(x2_ff) - 15'(x1_ff);
         dy_b = 13'(y2_ff) - 13'(y1_ff);
      end else begin
         dx_a = 15'(x4_ff) - 15'(x3_ff);
         dy_a = 13'(y2_ff) - 13'(y3_ff);
         dx_b = 15'(x2_ff) - 15'(x3_ff);
         dy_b = 13'(y2_ff) - 13'(y3_ff);
      end
      div_req.start = (state_ff == ST_X4_GO) || (state_ff == ST_LI_GO)
                   || (state_ff == ST_RI_GO);
      if (state_ff == ST_X4_GO) begin
         div_req.num = 32'(prod_ff);
         div_req.den = dy_a;
      end else if (state_ff == ST_LI_GO) begin
         div_req.num = 32'(dx_a) <<< FB;
         div_req.den = dy_a;
      end else begin
         div_req.num = 32'(dx_b) <<< FB;
         div_req.den = dy_b;
      end
   end

   // span of the current row
   always_comb begin
      lfl  = $signed(lv_ff[PW-1:FB]);
      rfl  = $signed(rv_ff[PW-1:FB]);
      r_hi = phase_ff ? 9'(tfr_pkg::SCR_W - 1) : 9'(tfr_pkg::SCR_W);
      if (lfl[17]) begin
         lc = '0;
      end else if (lfl > 18'(tfr_pkg::SCR_W)) begin
         lc = 9'(tfr_pkg::SCR_W);
      end else begin
         lc = lfl[8:0];
      end
      if (rfl[17]) begin
         rc = '0;
      end else if (rfl > 18'($signed({1'b0, r_hi}))) begin
         rc = r_hi;
      end else begin
         rc = rfl[8:0];
      end
      if (lc < rc) begin
         s_col = 11'(lc);
         e_col = 10'(rc);
      end else begin
         s_col = 11'(rc) - 11'sd1;
         e_col = 10'(lc);
      end
      row_base = 17'(row_ff[7:0]) * 17'(tfr_pkg::SCR_W);
   end

   always_comb begin
      state_in     = state_ff;
      boot_in      = boot_ff;
      phase_in     = phase_ff;
      cmd_in       = cmd_ff;
      color_in     = color_ff;
      x1_in = x1_ff; y1_in = y1_ff; x2_in = x2_ff; y2_in = y2_ff;
      x3_in = x3_ff; y3_in = y3_ff;
      x4_in        = x4_ff;
      prod_in      = prod_ff;
      li_in        = li_ff;
      ri_in        = ri_ff;
      lv_in        = lv_ff;
      rv_in        = rv_ff;
      row_in       = row_ff;
      cnt_in       = cnt_ff;
      span_addr_in = span_addr_ff;
      span_cnt_in  = span_cnt_ff;
      clr_addr_in  = clr_addr_ff;
      rd_val_in    = rd_val_ff;
      culled_in    = culled_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_waddr    = clr_addr_ff;
      ram_wdata    = color_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in      = req_tuser;
               x1_in       = $signed(req_tdata[11:0]);
               y1_in       = $signed(req_tdata[23:12]);
               x2_in       = $signed(req_tdata[35:24]);
               y2_in       = $signed(req_tdata[47:36]);
               x3_in       = $signed(req_tdata[59:48]);
               y3_in       = $signed(req_tdata[71:60]);
               color_in    = req_tdata[79:72];
               rd_val_in   = '0;
               culled_in   = 1'b0;
               phase_in    = 1'b0;
               clr_addr_in = '0;
               unique case (req_tuser)
                  tfr_pkg::CMD_CLEAR: state_in = ST_CLEAR;
                  tfr_pkg::CMD_WRITE: state_in = ST_WRITE;
                  tfr_pkg::CMD_READ:  state_in = ST_READ;
                  default:            state_in = ST_CULL;
               endcase
            end
         end
         ST_CLEAR: begin
            ram_we      = 1'b1;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(tfr_pkg::PIXELS - 1)) begin
               boot_in  = 1'b0;
               state_in = boot_ff ? ST_IDLE : ST_FINISH;
            end
         end
         ST_WRITE: begin
            ram_we    = pix_in_range;
            ram_waddr = pix_addr;
            state_in  = ST_FINISH;
         end
         ST_READ: begin
            state_in = ST_RDWAIT;
         end
         ST_RDWAIT: begin
            rd_val_in = pix_in_range ? ram_rdata : 8'd0;
            state_in  = ST_FINISH;
         end
         ST_CULL: begin
            if ((n1 && n2 && n3) || (p1 && p2 && p3)) begin
               culled_in = 1'b1;
               state_in  = ST_FINISH;
            end else begin
               x1_in = sx1; y1_in = sy1; x2_in = sx2; y2_in = sy2;
               x3_in = sx3; y3_in = sy3;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in = 26'(dx_a) * 26'(dy_b);
            if (y3_ff == y1_ff) begin
               culled_in = 1'b1;
               state_in  = ST_FINISH;
            end else begin
               state_in = ST_X4_GO;
            end
         end
         ST_X4_GO: state_in = ST_X4_WAIT;
         ST_X4_WAIT: begin
            if (div_rsp.done) begin
               x4_in    = div_rsp.quot[13:0] + 14'(x1_ff);
               state_in = (y2_ff == y1_ff) ? ST_LOW : ST_LI_GO;
            end
         end
         ST_LI_GO: state_in = ST_LI_WAIT;
         ST_LI_WAIT: begin
            if (div_rsp.done) begin
               li_in    = div_rsp.quot;
               state_in = ST_RI_GO;
            end
         end
         ST_RI_GO: state_in = ST_RI_WAIT;
         ST_RI_WAIT: begin
            if (div_rsp.done) begin
               ri_in = div_rsp.quot;
               if (!phase_ff) begin
                  lv_in  = PW'(x1_ff) <<< FB;
                  row_in = 13'(y1_ff);
                  cnt_in = 13'(dy_b);
               end else begin
                  lv_in  = PW'(x3_ff) <<< FB;
                  row_in = 13'(y3_ff);
                  cnt_in = 13'(-dy_b) + 13'd1;
               end
               rv_in    = lv_in;
               state_in = ST_ROW;
            end
         end
         ST_ROW: begin
            if (cnt_ff == 13'd0) begin
               state_in = phase_ff ? ST_FINISH : ST_LOW;
            end else begin
               lv_in        = phase_ff ? lv_ff - PW'(li_ff) : lv_ff + PW'(li_ff);
               rv_in        = phase_ff ? rv_ff - PW'(ri_ff) : rv_ff + PW'(ri_ff);
               row_in       = phase_ff ? row_ff - 13'sd1 : row_ff + 13'sd1;
               cnt_in       = cnt_ff - 13'd1;
               span_addr_in = $signed(row_base) + 17'(s_col);
               span_cnt_in  = 10'($signed({1'b0, e_col}) - s_col);
               if (row_ff[12]) begin
                  state_in = phase_ff ? ST_FINISH : ST_ROW;
               end else if (row_ff >= 13'(tfr_pkg::DRAW_ROWS)) begin
                  state_in = phase_ff ? ST_ROW : ST_LOW;
               end else begin
                  state_in = ST_PIX;
               end
            end
         end
         ST_PIX: begin
            ram_we    = !span_addr_ff[16];
            ram_waddr = span_addr_ff[AW-1:0];
            if (span_cnt_ff == 10'd0) begin
               state_in = ST_ROW;
            end else begin
               span_addr_in = span_addr_ff + 17'sd1;
               span_cnt_in  = span_cnt_ff - 10'd1;
            end
         end
         ST_LOW: begin
            phase_in = 1'b1;
            state_in = (y2_ff == y3_ff) ? ST_FINISH : ST_LI_GO;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {culled_ff, rd_val_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         boot_ff      <= 1'b1;
         color_ff     <= '0;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         boot_ff      <= boot_in;
         color_ff     <= color_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
      end
      cmd_ff       <= cmd_in;
      x1_ff <= x1_in; y1_ff <= y1_in; x2_ff <= x2_in; y2_ff <= y2_in;
      x3_ff <= x3_in; y3_ff <= y3_in;
      x4_ff        <= x4_in;
      prod_ff      <= prod_in;
      li_ff        <= li_in;
      ri_ff        <= ri_in;
      lv_ff        <= lv_in;
      rv_ff        <= rv_in;
      row_ff       <= row_in;
      cnt_ff       <= cnt_in;
      span_addr_ff <= span_addr_in;
      span_cnt_ff  <= span_cnt_in;
      rd_val_ff    <= rd_val_in;
      culled_ff    <= culled_in;
      rsp_data_ff  <= rsp_data_in;
   end

   a_pix_in_store: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PIX && !span_addr_ff[16]) |->
         (span_addr_ff < 17'(tfr_pkg::PIXELS)))
      else $error("span address beyond frame store");

   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_X4_WAIT || state_ff == ST_LI_WAIT
                        || state_ff == ST_RI_WAIT))
      else $error("divider result with no waiting step");

   a_boot_blocks_requests: assert property (@(posedge clock) disable iff (reset)
      boot_ff |-> !req_tready)
      else $error("request taken during reset sweep");

   a_fill_cmd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROW || state_ff == ST_PIX) |-> (cmd_ff == tfr_pkg::CMD_FILL))
      else $error("span walk outside a fill");

endmodule

`default_nettype wire

>>> hw/rtl/tfr_ram.sv
// ----------------------------------------------------------------------------
// tfr_ram
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tfr_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [DATA_W-1:0]        wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

>>> hw/rtl/tfr_div.sv
// ----------------------------------------------------------------------------
// tfr_div
// Signed truncating divider, restoring, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tfr_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tfr_pkg::div_req_type div_req,
   output tfr_pkg::div_rsp_type      div_rsp
);

   localparam int QW = tfr_pkg::NUM_W - 1;
   localparam int RW = tfr_pkg::DEN_W - 1;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [4:0]    step_ff, step_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic [QW-1:0] q_ff, q_in;
   logic [RW-1:0] dmag_ff, dmag_in;
   logic          neg_ff, neg_in;

   logic [RW:0]   trial;
   logic          ge;
   logic signed [tfr_pkg::NUM_W-1:0] num_abs;
   logic signed [tfr_pkg::DEN_W-1:0] den_abs;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      dmag_in = dmag_ff;
      neg_in  = neg_ff;
      trial   = {rem_ff, q_ff[QW-1]};
      ge      = trial >= {1'b0, dmag_ff};
      num_abs = div_req.num[tfr_pkg::NUM_W-1] ? -div_req.num : div_req.num;
      den_abs = div_req.den[tfr_pkg::DEN_W-1] ? -div_req.den : div_req.den;
      if (div_req.start) begin
         busy_in = 1'b1;
         step_in = 5'(tfr_pkg::DIV_STEPS - 1);
         rem_in  = '0;
         q_in    = num_abs[QW-1:0];
         dmag_in = den_abs[RW-1:0];
         neg_in  = div_req.num[tfr_pkg::NUM_W-1] ^ div_req.den[tfr_pkg::DEN_W-1];
      end else if (busy_ff) begin
         rem_in = ge ? RW'(trial - {1'b0, dmag_ff}) : trial[RW-1:0];
         q_in   = {q_ff[QW-2:0], ge};
         if (step_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      dmag_ff <= dmag_in;
      neg_ff  <= neg_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = neg_ff ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff});

endmodule

`default_nettype wire
